// ----- sv/nearest_upsample_and_gradient_sum_unit_macros.svh -----
// Assertion macros used by the checker of the upsample and gradient sum unit.
`ifndef NEAREST_UPSAMPLE_AND_GRADIENT_SUM_UNIT_MACROS_SVH
`define NEAREST_UPSAMPLE_AND_GRADIENT_SUM_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define NUSG_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define NUSG_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/nusg_pkg.sv -----
// Package: widths, register indexes, reset values and sequencer states of the unit.
package nusg_pkg;

   localparam int DEF_MAX_HEIGHT   = 128;
   localparam int DEF_MAX_WIDTH    = 128;
   localparam int DEF_MAX_CHANNELS = 64;
   localparam int DEF_MAX_SCALE    = 8;

   localparam int VAL_W      = 32;
   localparam int IDX_W      = 26;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] REG_MODE      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_IN_HEIGHT = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_IN_WIDTH  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_CHANNELS  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SCALE     = 3'd4;

   localparam logic MODE_FORWARD  = 1'b0;
   localparam logic MODE_BACKWARD = 1'b1;

   localparam logic [7:0] RST_IN_HEIGHT = 8'd1;
   localparam logic [7:0] RST_IN_WIDTH  = 8'd1;
   localparam logic [6:0] RST_CHANNELS  = 7'd1;
   localparam logic [3:0] RST_SCALE     = 4'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_F_OH,
      ST_F_OW,
      ST_F_WS,
      ST_F_POS,
      ST_F_BASE,
      ST_F_STRIDE,
      ST_F_EMIT,
      ST_B_SLOT,
      ST_B_ROW,
      ST_B_IDX,
      ST_B_SUM
   } state_type;

endpackage

// ----- sv/nusg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nusg_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 8192
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/nearest_upsample_and_gradient_sum_unit.sv -----
// Top level: nearest-neighbor 2D upsampling and its gradient block sum.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------------------
//  req_     | in        | req_valid/req_ready  | req_value
//  rsp_     | out       | rsp_valid/rsp_ready  | rsp_value_res, rsp_index, rsp_last_of_run,
//           |           |                      | rsp_frame_done, rsp_saturated
//  csr_     | in        | csr_we               | csr_addr, csr_wdata
//
//  Forward request: index set-up, then scale*scale copies; backward: slot, row, index, sum.
//  One shared 26-bit multiply-add unit yields one index product per cycle; the
//  backward path reads one accumulator RAM entry before the sum.
//  Reset (synchronous) clears the control registers and counters; the accumulator RAM needs
//  no clearing pass, since each block's top-left element writes its entry first.
//  A stalled rsp_ holds its result; req_ready is high only while the sequencer idles.
module nearest_upsample_and_gradient_sum_unit
   import nusg_pkg::*;
#(
   parameter int MAX_HEIGHT   = DEF_MAX_HEIGHT,
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_SCALE    = DEF_MAX_SCALE
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [VAL_W-1:0] req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [VAL_W-1:0] rsp_value_res,
   output logic [IDX_W-1:0]        rsp_index,
   output logic                    rsp_last_of_run,
   output logic                    rsp_frame_done,
   output logic                    rsp_saturated,
   input  logic                    csr_we,
   input  logic [CSR_ADDR_W-1:0]   csr_addr,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   // Accumulator store: one entry per column and channel of a small-tensor row.
   localparam int ACC_DEPTH = MAX_WIDTH * MAX_CHANNELS;
   localparam int AW  = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   // Widths of the clamped limits (hold the maximum itself).
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CW  = $clog2(MAX_CHANNELS + 1);
   localparam int SW  = $clog2(MAX_SCALE + 1);
   // Widths of the position counters (hold up to the maximum minus one).
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int COW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int SCW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

   state_type state_ff, state_in;

   // Configuration registers, raw as written.
   logic       cfg_mode_ff;
   logic [7:0] cfg_height_ff;
   logic [7:0] cfg_width_ff;
   logic [6:0] cfg_chan_ff;
   logic [3:0] cfg_scale_ff;
   logic       cfg_hit;

   logic [HW-1:0] h_lim;
   logic [WW-1:0] w_lim;
   logic [CW-1:0] c_lim;
   logic [SW-1:0] s_lim;
   logic [SW-1:0] sub_lim;

   // Position of the next request: small tensor in forward mode; in backward mode
   // the large-tensor position split into block (row/col) and offset (sub_row/sub_col).
   logic [RW-1:0]  row_ff, row_in;
   logic [COW-1:0] col_ff, col_in;
   logic [CHW-1:0] chan_ff, chan_in;
   logic [SCW-1:0] sub_row_ff, sub_row_in;
   logic [SCW-1:0] sub_col_ff, sub_col_in;
   logic           adv;

   // Copy position inside the block while emitting forward results.
   logic [SCW-1:0] e_row_ff, e_col_ff;

   logic signed [VAL_W-1:0] val_ff;
   logic [IDX_W-1:0]        t_ff, u_ff, outw_ff, stride_ff, idx_ff, rowbase_ff;
   logic [AW-1:0]           slot_ff;

   // Shared multiply-add unit; everything modulo 2^26 like the index field.
   logic [IDX_W-1:0] mul_a, mul_b, mul_c, mac_res;

   logic             ram_we, ram_re;
   logic [VAL_W:0]   ram_rdata, ram_wdata;

   logic signed [VAL_W:0]   sum_wide;
   logic signed [VAL_W-1:0] sum_sat;
   logic                    clip;

   logic frame_end, block_start, block_end, emit_last, emit_row_end, out_free, load_out;

   // ------------------------------------------------------------------
   // Configuration: any known index restarts the frame position.
   // ------------------------------------------------------------------
   assign cfg_hit = csr_we && (csr_addr == REG_MODE || csr_addr == REG_IN_HEIGHT ||
                               csr_addr == REG_IN_WIDTH || csr_addr == REG_CHANNELS ||
                               csr_addr == REG_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode_ff   <= MODE_FORWARD;
         cfg_height_ff <= RST_IN_HEIGHT;
         cfg_width_ff  <= RST_IN_WIDTH;
         cfg_chan_ff   <= RST_CHANNELS;
         cfg_scale_ff  <= RST_SCALE;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MODE:      cfg_mode_ff   <= csr_wdata[0];
            REG_IN_HEIGHT: cfg_height_ff <= csr_wdata[7:0];
            REG_IN_WIDTH:  cfg_width_ff  <= csr_wdata[7:0];
            REG_CHANNELS:  cfg_chan_ff   <= csr_wdata[6:0];
            REG_SCALE:     cfg_scale_ff  <= csr_wdata[3:0];
            default: ;  // drop writes to unknown indexes
         endcase
      end
   end

   // Clamp each dimension to 1 .. its maximum.
   always_comb begin
      if (cfg_height_ff == '0)              h_lim = HW'(1);
      else if (32'(cfg_height_ff) > MAX_HEIGHT) h_lim = HW'(MAX_HEIGHT);
      else                                  h_lim = HW'(cfg_height_ff);

      if (cfg_width_ff == '0)               w_lim = WW'(1);
      else if (32'(cfg_width_ff) > MAX_WIDTH) w_lim = WW'(MAX_WIDTH);
      else                                  w_lim = WW'(cfg_width_ff);

      if (cfg_chan_ff == '0)                c_lim = CW'(1);
      else if (32'(cfg_chan_ff) > MAX_CHANNELS) c_lim = CW'(MAX_CHANNELS);
      else                                  c_lim = CW'(cfg_chan_ff);

      if (cfg_scale_ff == '0)               s_lim = SW'(1);
      else if (32'(cfg_scale_ff) > MAX_SCALE) s_lim = SW'(MAX_SCALE);
      else                                  s_lim = SW'(cfg_scale_ff);
   end

   // Forward mode walks the small tensor, so the block offsets never move there.
   assign sub_lim = (cfg_mode_ff == MODE_BACKWARD) ? s_lim : SW'(1);

   // ------------------------------------------------------------------
   // Position counters, innermost first: channel, sub_col, col, sub_row, row.
   // ------------------------------------------------------------------
   always_comb begin
      chan_in    = chan_ff;
      sub_col_in = sub_col_ff;
      col_in     = col_ff;
      sub_row_in = sub_row_ff;
      row_in     = row_ff;
      if (CW'(chan_ff) + CW'(1) < c_lim) begin
         chan_in = chan_ff + CHW'(1);
      end else begin
         chan_in = '0;
         if (SW'(sub_col_ff) + SW'(1) < sub_lim) begin
            sub_col_in = sub_col_ff + SCW'(1);
         end else begin
            sub_col_in = '0;
            if (WW'(col_ff) + WW'(1) < w_lim) begin
               col_in = col_ff + COW'(1);
            end else begin
               col_in = '0;
               if (SW'(sub_row_ff) + SW'(1) < sub_lim) begin
                  sub_row_in = sub_row_ff + SCW'(1);
               end else begin
                  sub_row_in = '0;
                  if (HW'(row_ff) + HW'(1) < h_lim) begin
                     row_in = row_ff + RW'(1);
                  end else begin
                     row_in = '0;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         row_ff     <= '0;
         col_ff     <= '0;
         chan_ff    <= '0;
         sub_row_ff <= '0;
         sub_col_ff <= '0;
      end else if (adv) begin
         row_ff     <= row_in;
         col_ff     <= col_in;
         chan_ff    <= chan_in;
         sub_row_ff <= sub_row_in;
         sub_col_ff <= sub_col_in;
      end
   end

   // Last element of the small tensor; same test in both modes.
   assign frame_end = (HW'(row_ff) == h_lim - HW'(1)) &&
                      (WW'(col_ff) == w_lim - WW'(1)) &&
                      (CW'(chan_ff) == c_lim - CW'(1));
   assign block_start  = (sub_row_ff == '0) && (sub_col_ff == '0);
   assign block_end    = (SW'(sub_row_ff) == s_lim - SW'(1)) &&
                         (SW'(sub_col_ff) == s_lim - SW'(1));
   assign emit_row_end = (SW'(e_col_ff) == s_lim - SW'(1));
   assign emit_last    = (SW'(e_row_ff) == s_lim - SW'(1)) && emit_row_end;

   assign out_free = !rsp_valid || rsp_ready;

   // ------------------------------------------------------------------
   // Shared multiply-add unit.
   // ------------------------------------------------------------------
   assign mac_res = mul_a * mul_b + mul_c;

   // ------------------------------------------------------------------
   // Sequencer: next state, multiply-add operands, RAM strobes, result load.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mul_a    = '0;
      mul_b    = '0;
      mul_c    = '0;
      ram_re   = 1'b0;
      ram_we   = 1'b0;
      adv      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (cfg_mode_ff == MODE_BACKWARD) ? ST_B_SLOT : ST_F_OH;
            end
         end
         // Forward: base = ((row*s)*(w*s) + col*s)*c + chan, stride = (w*s)*c.
         ST_F_OH: begin
            mul_a    = IDX_W'(row_ff);
            mul_b    = IDX_W'(s_lim);
            state_in = ST_F_OW;
         end
         ST_F_OW: begin
            mul_a    = IDX_W'(col_ff);
            mul_b    = IDX_W'(s_lim);
            state_in = ST_F_WS;
         end
         ST_F_WS: begin
            mul_a    = IDX_W'(w_lim);
            mul_b    = IDX_W'(s_lim);
            state_in = ST_F_POS;
         end
         ST_F_POS: begin
            mul_a    = t_ff;
            mul_b    = outw_ff;
            mul_c    = u_ff;
            state_in = ST_F_BASE;
         end
         ST_F_BASE: begin
            mul_a    = t_ff;
            mul_b    = IDX_W'(c_lim);
            mul_c    = IDX_W'(chan_ff);
            state_in = ST_F_STRIDE;
         end
         ST_F_STRIDE: begin
            mul_a    = outw_ff;
            mul_b    = IDX_W'(c_lim);
            state_in = ST_F_EMIT;
         end
         // Send one copy per cycle while the output register can take it.
         ST_F_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               if (emit_last) begin
                  adv      = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         // Backward: slot = col*c + chan, index = (row*w + col)*c + chan.
         ST_B_SLOT: begin
            mul_a    = IDX_W'(col_ff);
            mul_b    = IDX_W'(c_lim);
            mul_c    = IDX_W'(chan_ff);
            state_in = ST_B_ROW;
         end
         ST_B_ROW: begin
            mul_a    = IDX_W'(row_ff);
            mul_b    = IDX_W'(w_lim);
            mul_c    = IDX_W'(col_ff);
            ram_re   = 1'b1;
            state_in = ST_B_IDX;
         end
         ST_B_IDX: begin
            mul_a    = t_ff;
            mul_b    = IDX_W'(c_lim);
            mul_c    = IDX_W'(chan_ff);
            state_in = ST_B_SUM;
         end
         // Write the sum back; at block end hold here until the output register can take the result.
         // A repeated write stores the same word, since the read data holds.
         ST_B_SUM: begin
            ram_we = 1'b1;
            if (!block_end) begin
               adv      = 1'b1;
               state_in = ST_IDLE;
            end else if (out_free) begin
               load_out = 1'b1;
               adv      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   // ------------------------------------------------------------------
   // Datapath registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         val_ff   <= req_value;
         e_row_ff <= '0;
         e_col_ff <= '0;
      end
      unique case (state_ff)
         ST_F_OH:     t_ff      <= mac_res;
         ST_F_OW:     u_ff      <= mac_res;
         ST_F_WS:     outw_ff   <= mac_res;
         ST_F_POS:    t_ff      <= mac_res;
         ST_F_BASE: begin
            idx_ff     <= mac_res;
            rowbase_ff <= mac_res;
         end
         ST_F_STRIDE: stride_ff <= mac_res;
         ST_F_EMIT: begin
            // Step to the next copy: along the row by c, to the next row by stride.
            if (out_free && !emit_last) begin
               if (emit_row_end) begin
                  e_col_ff   <= '0;
                  e_row_ff   <= e_row_ff + SCW'(1);
                  rowbase_ff <= rowbase_ff + stride_ff;
                  idx_ff     <= rowbase_ff + stride_ff;
               end else begin
                  e_col_ff <= e_col_ff + SCW'(1);
                  idx_ff   <= idx_ff + IDX_W'(c_lim);
               end
            end
         end
         ST_B_SLOT:   slot_ff   <= mac_res[AW-1:0];
         ST_B_ROW:    t_ff      <= mac_res;
         ST_B_IDX:    idx_ff    <= mac_res;
         default: ;
      endcase
   end

   // ------------------------------------------------------------------
   // Block sum: first element of a block overwrites, later ones add and clip.
   // ------------------------------------------------------------------
   always_comb begin
      if (block_start) begin
         sum_wide = {val_ff[VAL_W-1], val_ff};
         clip     = 1'b0;
      end else begin
         sum_wide = $signed({ram_rdata[VAL_W-1], ram_rdata[VAL_W-1:0]}) +
                    $signed({val_ff[VAL_W-1], val_ff});
         clip     = ram_rdata[VAL_W];
      end
      sum_sat = sum_wide[VAL_W-1:0];
      if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
         sum_sat = sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
         clip    = 1'b1;
      end
   end

   assign ram_wdata = {clip, sum_sat};

   nusg_ram #(
      .WIDTH (VAL_W + 1),
      .DEPTH (ACC_DEPTH)
   ) u_acc_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (slot_ff),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (slot_ff),
      .rdata (ram_rdata)
   );

   // ------------------------------------------------------------------
   // Output register: load a result when free or being taken, else hold.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (load_out) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_index <= idx_ff;
         if (state_ff == ST_B_SUM) begin
            rsp_value_res   <= sum_sat;
            rsp_last_of_run <= 1'b1;
            rsp_frame_done  <= frame_end;
            rsp_saturated   <= clip;
         end else begin
            rsp_value_res   <= val_ff;
            rsp_last_of_run <= emit_last;
            rsp_frame_done  <= emit_last && frame_end;
            rsp_saturated   <= 1'b0;
         end
      end
   end

endmodule

// ----- sv/nusg_checker.sv -----
// Port-level checker for the upsample and gradient sum unit, bound to the top level.
`include "nearest_upsample_and_gradient_sum_unit_macros.svh"

module nusg_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_value_res,
   input logic [25:0] rsp_index,
   input logic        rsp_last_of_run,
   input logic        rsp_frame_done,
   input logic        rsp_saturated
);

   logic        rsp_stall;
   logic [60:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_value_res, rsp_index, rsp_last_of_run, rsp_frame_done,
                       rsp_saturated};

   // One request at a time: the sequencer leaves idle right after taking one.
   `NUSG_ASSERT_NXT(a_busy_after_req, req_valid && req_ready, !req_ready, "ready after request")

   // A stalled result holds.
   `NUSG_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_word), "result changed")

   // The end of the frame is always the end of a run.
   `NUSG_ASSERT_IMP(a_frame_end, rsp_valid && rsp_frame_done, rsp_last_of_run, "early frame end")

   // Only block sums clip, and each block sum is the last of its run.
   `NUSG_ASSERT_IMP(a_sat_on_sum, rsp_valid && !rsp_last_of_run, !rsp_saturated, "copy saturated")

endmodule

bind nearest_upsample_and_gradient_sum_unit nusg_checker u_checker (.*);

// ----- test/tb_nearest_upsample_and_gradient_sum_unit.sv -----
// Testbench for the nearest-neighbor upsample and gradient sum unit, self-checking.
`timescale 1ns / 100ps

import nusg_pkg::*;

localparam longint SUM_HIGH     = 64'sh0000_0000_7FFF_FFFF;
localparam longint SUM_LOW      = -64'sh0000_0000_8000_0000;
localparam int     SUM_SLOTS    = DEF_MAX_WIDTH * DEF_MAX_CHANNELS;
localparam int     REPORT_LIMIT = 200;

typedef struct packed {
   logic signed [VAL_W-1:0] value;
   logic [IDX_W-1:0]        index;
   logic                    last_of_run;
   logic                    frame_done;
   logic                    saturated;
} unit_result_type;

// Tracks register settings, the frame position and the block sums of the unit,
// and holds the results that each accepted request must produce, oldest first.
class upsample_tracker;
   logic       mode_bit   = MODE_FORWARD;
   logic [7:0] height_reg = RST_IN_HEIGHT;
   logic [7:0] width_reg  = RST_IN_WIDTH;
   logic [6:0] chan_reg   = RST_CHANNELS;
   logic [3:0] scale_reg  = RST_SCALE;

   int unsigned row_pos  = 0;
   int unsigned col_pos  = 0;
   int unsigned chan_pos = 0;

   bit signed [VAL_W-1:0] block_sum  [SUM_SLOTS];
   bit                    block_clip [SUM_SLOTS];

   unit_result_type awaited[$];

   int unsigned results_seen = 0;
   int unsigned grad_results = 0;
   int unsigned error_count  = 0;

   function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function void get_sizes(output int unsigned h, w, c, s);
      h = clamp_dim(32'(height_reg), DEF_MAX_HEIGHT);
      w = clamp_dim(32'(width_reg), DEF_MAX_WIDTH);
      c = clamp_dim(32'(chan_reg), DEF_MAX_CHANNELS);
      s = clamp_dim(32'(scale_reg), DEF_MAX_SCALE);
   endfunction

   function void write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      case (addr)
         REG_MODE:      mode_bit   = data[0];
         REG_IN_HEIGHT: height_reg = data;
         REG_IN_WIDTH:  width_reg  = data;
         REG_CHANNELS:  chan_reg   = data[6:0];
         REG_SCALE:     scale_reg  = data[3:0];
         default:       return;
      endcase
      row_pos  = 0;
      col_pos  = 0;
      chan_pos = 0;
   endfunction

   // Requests still needed to close the current frame.
   function int unsigned items_left();
      int unsigned h, w, c, s, rows, cols;
      get_sizes(h, w, c, s);
      rows = (mode_bit == MODE_BACKWARD) ? h * s : h;
      cols = (mode_bit == MODE_BACKWARD) ? w * s : w;
      return rows * cols * c - ((row_pos * cols + col_pos) * c + chan_pos);
   endfunction

   function void step_position(int unsigned rows, int unsigned cols, int unsigned ch);
      if (chan_pos + 1 < ch) begin
         chan_pos++;
         return;
      end
      chan_pos = 0;
      if (col_pos + 1 < cols) begin
         col_pos++;
         return;
      end
      col_pos = 0;
      if (row_pos + 1 < rows) begin
         row_pos++;
         return;
      end
      row_pos = 0;
   endfunction

   function void note_request(logic signed [VAL_W-1:0] v);
      int unsigned      h, w, c, s, rows, cols, r, col, ch, ir, ic, sh, sw, slot;
      longint unsigned  flat;
      longint           total;
      bit               clip, frame_end;
      unit_result_type  res;
      get_sizes(h, w, c, s);
      if (mode_bit == MODE_FORWARD) begin
         r   = row_pos % h;
         col = col_pos % w;
         ch  = chan_pos % c;
         frame_end = (r == h - 1) && (col == w - 1) && (ch == c - 1);
         for (int unsigned dy = 0; dy < s; dy++) begin
            for (int unsigned dx = 0; dx < s; dx++) begin
               flat = ((longint'(r * s + dy) * (w * s) + (col * s + dx)) * c) + ch;
               res.value       = v;
               res.index       = flat[IDX_W-1:0];
               res.last_of_run = (dy == s - 1) && (dx == s - 1);
               res.frame_done  = res.last_of_run && frame_end;
               res.saturated   = 1'b0;
               awaited.push_back(res);
            end
         end
         step_position(h, w, c);
      end else begin
         rows = h * s;
         cols = w * s;
         r    = row_pos % rows;
         col  = col_pos % cols;
         ch   = chan_pos % c;
         ir   = r / s;
         ic   = col / s;
         sh   = r % s;
         sw   = col % s;
         slot = ic * c + ch;
         // top-left element of a block overwrites the entry and its clip bit
         if (sh == 0 && sw == 0) begin
            total = longint'(v);
            clip  = 1'b0;
         end else begin
            total = longint'(block_sum[slot]) + longint'(v);
            clip  = block_clip[slot];
         end
         if (total > SUM_HIGH) begin
            total = SUM_HIGH;
            clip  = 1'b1;
         end
         if (total < SUM_LOW) begin
            total = SUM_LOW;
            clip  = 1'b1;
         end
         block_sum[slot]  = total[VAL_W-1:0];
         block_clip[slot] = clip;
         if (sh == s - 1 && sw == s - 1) begin
            flat = (longint'(ir) * w + ic) * c + ch;
            res.value       = total[VAL_W-1:0];
            res.index       = flat[IDX_W-1:0];
            res.last_of_run = 1'b1;
            res.frame_done  = (ir == h - 1) && (ic == w - 1) && (ch == c - 1);
            res.saturated   = clip;
            awaited.push_back(res);
            grad_results++;
         end
         step_position(rows, cols, c);
      end
   endfunction

   function int unsigned pending();
      return awaited.size();
   endfunction

   task report(string what);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task check_response(unit_result_type got);
      unit_result_type want;
      results_seen++;
      if (awaited.size() == 0) begin
         report($sformatf("result with nothing pending: index %0d value %h",
                          got.index, got.value));
         return;
      end
      want = awaited.pop_front();
      if (got.value !== want.value)
         report($sformatf("value_res %h, wanted %h (index %0d)", got.value, want.value,
                          want.index));
      if (got.index !== want.index)
         report($sformatf("index %0d, wanted %0d", got.index, want.index));
      if (got.last_of_run !== want.last_of_run)
         report($sformatf("last_of_run %b, wanted %b (index %0d)", got.last_of_run,
                          want.last_of_run, want.index));
      if (got.frame_done !== want.frame_done)
         report($sformatf("frame_done %b, wanted %b (index %0d)", got.frame_done,
                          want.frame_done, want.index));
      if (got.saturated !== want.saturated)
         report($sformatf("saturated %b, wanted %b (index %0d)", got.saturated,
                          want.saturated, want.index));
   endtask
endclass

module tb_nearest_upsample_and_gradient_sum_unit;

   localparam int     CLK_HIGH      = 6;
   localparam int     CLK_LOW       = 6;
   localparam int     RESET_CYCLES  = 12;
   localparam int     SETTLE_CYCLES = 24;
   localparam int     HOLD_CYCLES   = 300;
   localparam int     HOLD_MARK_A   = 100;
   localparam int     HOLD_MARK_B   = 300;
   localparam int     RANDOM_ITEMS  = 120;
   localparam int     GRAD_TARGET   = 12;
   localparam longint RUN_LIMIT_NS  = 20_000_000;

   // register indexes that the unit does not decode
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED_FIRST = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_UNUSED_LAST  = 3'd7;

   typedef enum {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_style_type;
   typedef enum {CFG_FULL, CFG_ONE, CFG_STRAY, CFG_KEEP} cfg_style_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [VAL_W-1:0] req_value = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [VAL_W-1:0] rsp_value_res;
   logic [IDX_W-1:0]        rsp_index;
   logic                    rsp_last_of_run;
   logic                    rsp_frame_done;
   logic                    rsp_saturated;
   logic                    csr_we    = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr  = REG_MODE;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   upsample_tracker tracker = new;

   int unsigned burst_left = 0;
   int unsigned rand_items = 0;

   nearest_upsample_and_gradient_sum_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_res   (rsp_value_res),
      .rsp_index       (rsp_index),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_saturated   (rsp_saturated),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #(CLK_LOW) clock = 1'b1;
      #(CLK_HIGH) clock = 1'b0;
   end

   // Hard stop in case the unit hangs or drops results.
   initial begin
      #(RUN_LIMIT_NS);
      $display("RESULT: ERROR");
      $finish;
   end

   // Sample every accepted result at the rising edge and check it against the
   // oldest pending prediction.
   always @(posedge clock) begin : result_monitor
      unit_result_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.value       = rsp_value_res;
         seen.index       = rsp_index;
         seen.last_of_run = rsp_last_of_run;
         seen.frame_done  = rsp_frame_done;
         seen.saturated   = rsp_saturated;
         tracker.check_response(seen);
      end
   end

   // Result-side back pressure: switch between steady, random and sparse ready
   // patterns, and twice hold ready low for a long stretch so that the unit fills
   // up and stops taking requests while the sender keeps offering.
   initial begin : result_backpressure
      rx_style_type style;
      int unsigned  style_left, hold_left, next_hold, tick;
      logic         ready_bit;
      style      = RX_STEADY;
      style_left = 0;
      hold_left  = 0;
      next_hold  = 0;
      tick       = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            ready_bit = 1'b0;
         end else if ((next_hold == 0 && tracker.results_seen >= HOLD_MARK_A) ||
                      (next_hold == 1 && tracker.results_seen >= HOLD_MARK_B)) begin
            hold_left = HOLD_CYCLES - 1;
            next_hold++;
            ready_bit = 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = rx_style_type'($urandom_range(0, 2));
               style_left = $urandom_range(20, 80);
            end
            style_left--;
            case (style)
               RX_STEADY: ready_bit = 1'b1;
               RX_RANDOM: ready_bit = ($urandom_range(0, 3) != 0);
               default:   ready_bit = (tick % 3 == 0);
            endcase
         end
         rsp_ready <= ready_bit;
         @(negedge clock);
      end
   end

   // Offer one request; bursts of random length are separated by random gaps.
   // Called at a falling edge, returns at the falling edge after acceptance.
   task send_request(input logic signed [VAL_W-1:0] v);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(v);
      burst_left--;
      @(negedge clock);
   endtask

   // Drop valid, wait for every pending result, then let the unit finish any
   // trailing request that produces no result.
   task drain_unit();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves csr_we high; the caller lowers it after the last write.
   task write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_register(addr, data);
      @(negedge clock);
   endtask

   task write_settings(input logic [CSR_DATA_W-1:0] mode_data, height, width, chans, scl);
      write_csr(REG_MODE, mode_data);
      write_csr(REG_IN_HEIGHT, height);
      write_csr(REG_IN_WIDTH, width);
      write_csr(REG_CHANNELS, chans);
      write_csr(REG_SCALE, scl);
      csr_we <= 1'b0;
   endtask

   // Register value: small sizes mostly, extremes and out-of-range values when
   // wide is set. Unused upper bits are filled at random.
   function logic [CSR_DATA_W-1:0] pick_setting(logic [CSR_ADDR_W-1:0] addr, bit wide);
      logic [7:0] dim;
      case ($urandom_range(0, 4))
         0:       dim = 8'd0;
         1:       dim = 8'd1;
         2:       dim = 8'd128;
         3:       dim = 8'd255;
         default: dim = 8'($urandom);
      endcase
      case (addr)
         REG_MODE:      return 8'($urandom);
         REG_IN_HEIGHT,
         REG_IN_WIDTH:  return wide ? dim : 8'($urandom_range(1, 4));
         REG_CHANNELS:  return {1'($urandom), wide ? dim[6:0] : 7'($urandom_range(1, 3))};
         default:       return {4'($urandom), wide ? dim[3:0] : 4'($urandom_range(1, 3))};
      endcase
   endfunction

   // Mix of full-range, small, near-limit and fraction-only values.
   function logic signed [VAL_W-1:0] random_value();
      logic [16:0] low;
      low = 17'($urandom);
      case ($urandom_range(0, 4))
         0:       return $urandom;
         1:       return {{15{low[16]}}, low};
         2:       return 32'h7FFF_FFFF - $urandom_range(0, 255);
         3:       return 32'h8000_0000 + $urandom_range(0, 255);
         default: return $urandom & 32'h0000_FFFF;
      endcase
   endfunction

   // One random phase: change some registers (or none, or only an undecoded
   // index so the frame carries on), then send a full frame or a random run.
   task run_random_phase();
      cfg_style_type          cfg;
      int unsigned            pick, left, cap, n;
      bit                     wide, force_grad;
      logic [CSR_ADDR_W-1:0]  addr;
      logic [CSR_DATA_W-1:0]  mode_data;
      force_grad = (rand_items >= RANDOM_ITEMS);
      pick       = $urandom_range(0, 9);
      cfg        = (pick < 6 || force_grad) ? CFG_FULL :
                   (pick < 8) ? CFG_ONE : (pick == 8) ? CFG_STRAY : CFG_KEEP;
      wide       = !force_grad && ($urandom_range(0, 7) == 0);
      case (cfg)
         CFG_FULL: begin
            mode_data = pick_setting(REG_MODE, wide);
            if (force_grad) mode_data[0] = MODE_BACKWARD;
            write_settings(mode_data, pick_setting(REG_IN_HEIGHT, wide),
                           pick_setting(REG_IN_WIDTH, wide),
                           pick_setting(REG_CHANNELS, wide), pick_setting(REG_SCALE, wide));
         end
         CFG_ONE: begin
            addr = CSR_ADDR_W'($urandom_range(REG_MODE, REG_SCALE));
            write_csr(addr, pick_setting(addr, 1'b0));
            csr_we <= 1'b0;
         end
         CFG_STRAY: begin
            addr = CSR_ADDR_W'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST));
            write_csr(addr, 8'($urandom));
            csr_we <= 1'b0;
         end
         default: ;
      endcase
      left = tracker.items_left();
      cap  = (tracker.mode_bit == MODE_BACKWARD) ? 48 : 24;
      n    = (left <= cap && $urandom_range(0, 3) != 0) ? left : $urandom_range(3, 24);
      repeat (n) begin
         send_request(random_value());
         rand_items++;
      end
      drain_unit();
   endtask

   initial begin : stimulus
      logic signed [VAL_W-1:0] clip_run [12];
      clip_run = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                   32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                   32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004};
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: forward, 1x1x1, scale 2; the last copy of each request ends a frame.
      send_request(32'h7FFF_FFFF);
      send_request(32'h8000_0000);
      drain_unit();

      // Zero sizes and scale clamp up to 1, width 255 clamps to 128; the upper
      // mode bits are ignored.
      write_settings(8'hFE, 8'd0, 8'd255, 8'd0, 8'd0);
      send_request(32'h0000_0000);
      send_request(32'hFFFF_FFFF);
      drain_unit();

      // Backward 1x1x1, scale 2: clip high, clip low (clip bit stays set while
      // the sum comes back in range), then a clean block after a block start.
      write_settings({7'd0, MODE_BACKWARD}, 8'd1, 8'd1, 8'd1, 8'd2);
      foreach (clip_run[i]) send_request(clip_run[i]);
      drain_unit();

      // Channels and scale beyond their limits: 64 channels, scale 8.
      write_settings({7'h7F, MODE_FORWARD}, 8'd1, 8'd1, 8'hFF, 8'hFF);
      send_request(32'h1234_5678);
      drain_unit();

      // Full forward frame 2x2x2 at scale 3; the first long result hold lands here.
      write_settings({7'd0, MODE_FORWARD}, 8'd2, 8'd2, 8'd2, 8'd3);
      for (int k = 0; k < 8; k++) send_request(random_value());
      drain_unit();

      while (rand_items < RANDOM_ITEMS || tracker.grad_results < GRAD_TARGET)
         run_random_phase();

      if (tracker.error_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
